@@ rtl/asa_pkg.sv @@
// Shared types, constants and helper functions of the anti-aliased snake activation block.
package asa_pkg;

  localparam int unsigned SampleW   = 16;
  localparam int unsigned WinDepth  = 11;
  localparam int unsigned Taps      = 12;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 64;
  localparam int unsigned GainW     = 20;
  localparam int unsigned TapsPerReg = 4;

  localparam logic [3:0]  Lag      = 4'd5;
  localparam logic [3:0]  FarPos   = 4'd8;
  localparam logic [2:0]  CountMax = 3'd7;
  localparam logic [3:0]  LastTap  = 4'd11;
  localparam logic [2:0]  LastMac  = 3'd5;
  localparam logic [GainW-1:0] GainReset = 20'h10000;
  localparam logic [14:0] InvPiQ16 = 15'd20861;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_UP_LOW     = 3'd0,
    REG_UP_MID     = 3'd1,
    REG_UP_HIGH    = 3'd2,
    REG_DOWN_LOW   = 3'd3,
    REG_DOWN_MID   = 3'd4,
    REG_DOWN_HIGH  = 3'd5,
    REG_ALPHA_GAIN = 3'd6,
    REG_INV_BETA   = 3'd7
  } cfg_reg_e;

  // Back-end sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_UP_MAC,
    ST_UP_DRAIN,
    ST_SN_V,
    ST_SN_PH,
    ST_SN_FR,
    ST_SN_SIN,
    ST_SN_SQ,
    ST_SN_TERM,
    ST_SN_W,
    ST_DN_MUL,
    ST_DN_ACC,
    ST_OUT
  } asa_state_e;

  typedef logic [Taps-1:0][SampleW-1:0]     tap_arr_t;
  typedef logic [WinDepth-1:0][SampleW-1:0] win_arr_t;

  // One unit of work handed from the front to the back
  typedef struct packed {
    win_arr_t   win;
    logic [3:0] pos;
    logic       last;
  } asa_job_t;

  // Quarter-wave sine, Q.15
  function automatic logic [15:0] sine_q(input logic [4:0] idx);
    logic [15:0] r;
    begin
      case (idx)
        5'd0:  r = 16'd0;
        5'd1:  r = 16'd3212;
        5'd2:  r = 16'd6393;
        5'd3:  r = 16'd9512;
        5'd4:  r = 16'd12540;
        5'd5:  r = 16'd15447;
        5'd6:  r = 16'd18205;
        5'd7:  r = 16'd20788;
        5'd8:  r = 16'd23170;
        5'd9:  r = 16'd25330;
        5'd10: r = 16'd27245;
        5'd11: r = 16'd28899;
        5'd12: r = 16'd30274;
        5'd13: r = 16'd31357;
        5'd14: r = 16'd32138;
        5'd15: r = 16'd32610;
        default: r = 16'd32768;
      endcase
      return r;
    end
  endfunction

  // Clamp a wide signed value to the sample range
  function automatic logic [SampleW-1:0] sat_s16(input logic signed [39:0] v);
    logic [SampleW-1:0] r;
    begin
      if (v > 40'sd32767) r = 16'h7FFF;
      else if (v < -40'sd32768) r = 16'h8000;
      else r = v[SampleW-1:0];
      return r;
    end
  endfunction

endpackage

@@ rtl/asa_front.sv @@
// Front end: takes input beats, keeps the input window and issues output jobs.
module asa_front (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [asa_pkg::SampleW-1:0]      s_axis_tdata,
  input  logic                             s_axis_tlast,
  input  logic                             q_ready_i,
  output logic                             q_push_o,
  output asa_pkg::asa_job_t                q_job_o
);

  asa_pkg::win_arr_t win_q, win_d;
  logic [2:0] seen_q, seen_d;
  logic       far_q, far_d;
  logic [3:0] pos;
  logic       accept;
  logic       emit;

  assign s_axis_tready = q_ready_i;
  assign accept = s_axis_tvalid & q_ready_i;
  assign pos = far_q ? asa_pkg::FarPos : {1'b0, seen_q};

  // Shift in the new sample, or fill the window at the start of a sequence
  always_comb begin
    if ((seen_q == 3'd0) && !far_q) begin
      for (int s = 0; s < asa_pkg::WinDepth; s++) win_d[s] = s_axis_tdata;
    end else begin
      for (int s = 1; s < asa_pkg::WinDepth; s++) win_d[s] = win_q[s-1];
      win_d[0] = s_axis_tdata;
    end
  end

  // Advance the sequence position and decide whether outputs are due
  always_comb begin
    seen_d = seen_q;
    far_d  = far_q;
    emit   = 1'b0;
    if (s_axis_tlast) begin
      emit   = 1'b1;
      seen_d = 3'd0;
      far_d  = 1'b0;
    end else begin
      emit = (pos >= asa_pkg::Lag);
      if (seen_q < asa_pkg::CountMax) seen_d = seen_q + 3'd1;
      else far_d = 1'b1;
    end
  end

  assign q_push_o     = accept & emit;
  assign q_job_o.win  = win_d;
  assign q_job_o.pos  = pos;
  assign q_job_o.last = s_axis_tlast;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q  <= '0;
      seen_q <= 3'd0;
      far_q  <= 1'b0;
    end else if (accept) begin
      win_q  <= win_d;
      seen_q <= seen_d;
      far_q  <= far_d;
    end
  end

endmodule

@@ rtl/asa_queue.sv @@
// Two-entry job queue between the front and back ends.
module asa_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  asa_pkg::asa_job_t job_i,
  output logic              ready_o,
  output logic              valid_o,
  output asa_pkg::asa_job_t job_o,
  input  logic              pop_i
);

  asa_pkg::asa_job_t mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  assign ready_o = (cnt_q != 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign job_o   = mem_q[rd_q];
  assign do_push = push_i & ready_o;
  assign do_pop  = pop_i & valid_o;

  // Store entries
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= job_i;
  end

  // Move pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) wr_q <= ~wr_q;
      if (do_pop)  rd_q <= ~rd_q;
      if (do_push && !do_pop) cnt_q <= cnt_q + 2'd1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 2'd1;
    end
  end

endmodule

@@ rtl/asa_back.sv @@
// Back end: upsample points, snake curve and downsample MAC on a shared sequencer.
module asa_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           job_valid_i,
  input  asa_pkg::asa_job_t              job_i,
  output logic                           job_pop_o,
  input  asa_pkg::tap_arr_t              up_taps_i,
  input  asa_pkg::tap_arr_t              down_taps_i,
  input  logic [asa_pkg::GainW-1:0]      alpha_i,
  input  logic [asa_pkg::GainW-1:0]      inv_beta_i,
  output logic                           m_valid_o,
  input  logic                           m_ready_i,
  output logic [asa_pkg::SampleW-1:0]    m_data_o,
  output logic                           m_last_o
);

  asa_pkg::asa_state_e state_q, state_d;
  asa_pkg::asa_job_t   job_q;
  logic [2:0]  d_q;
  logic [3:0]  k_q;
  logic [2:0]  t_q;
  logic signed [35:0] acc_q;
  logic signed [31:0] prod_q;
  logic [15:0] v_q;
  logic [35:0] ph_q;
  logic [43:0] f_q;
  logic [15:0] s_q;
  logic [31:0] sq_q;
  logic [35:0] tb_q;
  logic [15:0] w_q;
  logic signed [31:0] dprod_q;
  logic signed [37:0] dacc_q;
  logic        ovalid_q, olast_q;
  logic [15:0] odata_q;

  logic        out_free, load_job, more_out;
  logic signed [7:0] rr, lo, hi, r, sv, rel, nrel;
  logic [3:0]  j, slot;
  logic [2:0]  d_first;
  logic signed [31:0] prod_d;
  logic [15:0] mag;
  logic [43:0] fa;
  logic [4:0]  idx;
  logic [14:0] fr;
  logic [15:0] s_d, s0, s1;
  logic [30:0] ip;
  logic [15:0] s2;
  logic [36:0] tbr;
  logic [16:0] term;
  logic signed [17:0] wsum;

  assign out_free = !ovalid_q || m_ready_i;
  assign more_out = job_q.last && (d_q != 3'd0);
  assign d_first  = (job_i.last && (job_i.pos < asa_pkg::Lag)) ?
                    job_i.pos[2:0] : asa_pkg::Lag[2:0];

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      asa_pkg::ST_IDLE:     if (job_valid_i) state_d = asa_pkg::ST_UP_MAC;
      asa_pkg::ST_UP_MAC:   if (t_q == asa_pkg::LastMac) state_d = asa_pkg::ST_UP_DRAIN;
      asa_pkg::ST_UP_DRAIN: state_d = asa_pkg::ST_SN_V;
      asa_pkg::ST_SN_V:     state_d = asa_pkg::ST_SN_PH;
      asa_pkg::ST_SN_PH:    state_d = asa_pkg::ST_SN_FR;
      asa_pkg::ST_SN_FR:    state_d = asa_pkg::ST_SN_SIN;
      asa_pkg::ST_SN_SIN:   state_d = asa_pkg::ST_SN_SQ;
      asa_pkg::ST_SN_SQ:    state_d = asa_pkg::ST_SN_TERM;
      asa_pkg::ST_SN_TERM:  state_d = asa_pkg::ST_SN_W;
      asa_pkg::ST_SN_W:     state_d = asa_pkg::ST_DN_MUL;
      asa_pkg::ST_DN_MUL:   state_d = asa_pkg::ST_DN_ACC;
      asa_pkg::ST_DN_ACC:
        state_d = (k_q == asa_pkg::LastTap) ? asa_pkg::ST_OUT : asa_pkg::ST_UP_MAC;
      asa_pkg::ST_OUT:
        if (out_free) state_d = more_out ? asa_pkg::ST_UP_MAC : asa_pkg::ST_IDLE;
      default:              state_d = asa_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    load_job = (state_q == asa_pkg::ST_IDLE) && job_valid_i;
  end
  assign job_pop_o = load_job;

  // Snake point index, clamped to the sequence edges
  always_comb begin
    rr = $signed({4'b0, k_q}) - $signed({4'b0, d_q, 1'b0}) - 8'sd5;
    lo = -$signed({3'b0, job_q.pos, 1'b0});
    hi = job_q.last ? 8'sd1 : 8'sd127;
    if (rr < lo) r = lo;
    else if (rr > hi) r = hi;
    else r = rr;
    j    = {t_q, 1'b0} + {3'b0, ~r[0]};
    sv   = r + 8'sd15 - $signed({4'b0, j});
    rel  = (sv >>> 1) - 8'sd5;
    nrel = -rel;
    if (nrel < 8'sd0) slot = 4'd0;
    else if (nrel > 8'sd10) slot = 4'd10;
    else slot = nrel[3:0];
    prod_d = 32'($signed(up_taps_i[j])) * 32'($signed(job_q.win[slot]));
  end

  // Phase fold, sine interpolation and the squared-sine snake term
  always_comb begin
    mag = v_q[15] ? 16'(-v_q) : v_q;
    fa  = (f_q > 44'h800_0000_0000) ? 44'(44'd0 - f_q) : f_q;
    idx = fa[43:39];
    fr  = fa[38:24];
    s0  = asa_pkg::sine_q(idx);
    s1  = asa_pkg::sine_q(5'(idx + 5'd1));
    ip  = 31'(s1 - s0) * 31'(fr);
    s_d = idx[4] ? asa_pkg::sine_q(idx) : 16'(s0 + ip[30:15]);
    s2   = 16'((sq_q + 32'd16384) >> 15);
    tbr  = 37'(tb_q) + 37'd262144;
    term = tbr[35:19];
    wsum = 18'($signed(v_q)) + $signed({1'b0, term});
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      asa_pkg::ST_IDLE: begin
        if (job_valid_i) begin
          job_q  <= job_i;
          dacc_q <= '0;
        end
      end
      asa_pkg::ST_UP_MAC: begin
        acc_q  <= (t_q == 3'd0) ? 36'sd0 : acc_q + 36'(prod_q);
        prod_q <= prod_d;
      end
      asa_pkg::ST_UP_DRAIN: acc_q <= acc_q + 36'(prod_q);
      asa_pkg::ST_SN_V:     v_q <= asa_pkg::sat_s16(40'((acc_q + 36'sd4096) >>> 13));
      asa_pkg::ST_SN_PH:    ph_q <= 36'(mag) * 36'(alpha_i);
      asa_pkg::ST_SN_FR:    f_q <= 44'(ph_q) * 44'(asa_pkg::InvPiQ16);
      asa_pkg::ST_SN_SIN:   s_q <= s_d;
      asa_pkg::ST_SN_SQ:    sq_q <= 32'(s_q) * 32'(s_q);
      asa_pkg::ST_SN_TERM:  tb_q <= 36'(inv_beta_i) * 36'(s2);
      asa_pkg::ST_SN_W:     w_q <= asa_pkg::sat_s16(40'(wsum));
      asa_pkg::ST_DN_MUL:
        dprod_q <= 32'($signed(down_taps_i[k_q])) * 32'($signed(w_q));
      asa_pkg::ST_DN_ACC:   dacc_q <= dacc_q + 38'(dprod_q);
      asa_pkg::ST_OUT: begin
        if (out_free) begin
          odata_q <= asa_pkg::sat_s16(40'((dacc_q + 38'sd8192) >>> 14));
          olast_q <= job_q.last && (d_q == 3'd0);
          dacc_q  <= '0;
        end
      end
      default: ;
    endcase
  end

  // Control counters and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= asa_pkg::ST_IDLE;
      d_q      <= 3'd0;
      k_q      <= 4'd0;
      t_q      <= 3'd0;
      ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_job) begin
        d_q <= d_first;
        k_q <= 4'd0;
        t_q <= 3'd0;
      end
      if (state_q == asa_pkg::ST_UP_MAC) t_q <= t_q + 3'd1;
      if (state_q == asa_pkg::ST_UP_DRAIN) t_q <= 3'd0;
      if (state_q == asa_pkg::ST_DN_ACC)
        k_q <= (k_q == asa_pkg::LastTap) ? 4'd0 : k_q + 4'd1;
      if ((state_q == asa_pkg::ST_OUT) && out_free) begin
        ovalid_q <= 1'b1;
        if (more_out) d_q <= d_q - 3'd1;
      end else if (m_ready_i) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  assign m_valid_o = ovalid_q;
  assign m_data_o  = odata_q;
  assign m_last_o  = olast_q;

endmodule

@@ rtl/antialiased_snake_activation_top.sv @@
// Top level: configuration registers, front end, job queue and back end.
// Each output beat is built from 12 snake points on the shared MAC/snake
// sequencer; a last beat with six pending outputs occupies the back end until
// all six are sent, and the back end takes no new job before then.
// Reset clears the window, the sequence count, the queue and the output stage;
// taps reset to zero and both gains to 1.0.
module antialiased_snake_activation_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [asa_pkg::SampleW-1:0]      s_axis_tdata,  // [15:0] sample_in
  input  logic                             s_axis_tlast,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [asa_pkg::SampleW-1:0]      m_axis_tdata,  // [15:0] sample_out
  output logic                             m_axis_tlast,
  input  logic                             cfg_we_i,
  input  logic [asa_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [asa_pkg::CfgDataW-1:0]     cfg_data_i
);

  asa_pkg::tap_arr_t up_taps_q, down_taps_q;
  logic [asa_pkg::GainW-1:0] alpha_q, inv_beta_q;
  asa_pkg::asa_job_t push_job, pop_job;
  logic q_ready, q_push, q_valid, q_pop;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      up_taps_q   <= '0;
      down_taps_q <= '0;
      alpha_q     <= asa_pkg::GainReset;
      inv_beta_q  <= asa_pkg::GainReset;
    end else if (cfg_we_i) begin
      unique case (asa_pkg::cfg_reg_e'(cfg_idx_i))
        asa_pkg::REG_UP_LOW:
          for (int q = 0; q < 4; q++) up_taps_q[q] <= cfg_data_i[16*q +: 16];
        asa_pkg::REG_UP_MID:
          for (int q = 0; q < 4; q++) up_taps_q[4+q] <= cfg_data_i[16*q +: 16];
        asa_pkg::REG_UP_HIGH:
          for (int q = 0; q < 4; q++) up_taps_q[8+q] <= cfg_data_i[16*q +: 16];
        asa_pkg::REG_DOWN_LOW:
          for (int q = 0; q < 4; q++) down_taps_q[q] <= cfg_data_i[16*q +: 16];
        asa_pkg::REG_DOWN_MID:
          for (int q = 0; q < 4; q++) down_taps_q[4+q] <= cfg_data_i[16*q +: 16];
        asa_pkg::REG_DOWN_HIGH:
          for (int q = 0; q < 4; q++) down_taps_q[8+q] <= cfg_data_i[16*q +: 16];
        asa_pkg::REG_ALPHA_GAIN: alpha_q    <= cfg_data_i[asa_pkg::GainW-1:0];
        asa_pkg::REG_INV_BETA:   inv_beta_q <= cfg_data_i[asa_pkg::GainW-1:0];
        default: ;
      endcase
    end
  end

  asa_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .q_ready_i     (q_ready),
    .q_push_o      (q_push),
    .q_job_o       (push_job)
  );

  asa_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .job_i   (push_job),
    .ready_o (q_ready),
    .valid_o (q_valid),
    .job_o   (pop_job),
    .pop_i   (q_pop)
  );

  asa_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (q_valid),
    .job_i       (pop_job),
    .job_pop_o   (q_pop),
    .up_taps_i   (up_taps_q),
    .down_taps_i (down_taps_q),
    .alpha_i     (alpha_q),
    .inv_beta_i  (inv_beta_q),
    .m_valid_o   (m_axis_tvalid),
    .m_ready_i   (m_axis_tready),
    .m_data_o    (m_axis_tdata),
    .m_last_o    (m_axis_tlast)
  );

endmodule
